// ===== rtl/core/cags_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cags_pkg: shared definitions of the cave grid smoother
// Widths, register indexes, reset values, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cags_pkg;

   localparam int CELL_W       = 64;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 8;
   localparam int DIM_W        = 7;
   localparam int PASS_W       = 4;
   localparam int THR_W        = 4;
   localparam int CNT_W        = 4;
   localparam int COL_IDX_W    = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS_COUNT     = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_THRESHOLD = 8'd3;

   localparam logic [DIM_W-1:0]  RST_GRID_ROWS      = 7'd64;
   localparam logic [DIM_W-1:0]  RST_GRID_COLS      = 7'd64;
   localparam logic [PASS_W-1:0] RST_PASS_COUNT     = 4'd8;
   localparam logic [THR_W-1:0]  RST_WALL_THRESHOLD = 4'd5;

   localparam logic [DIM_W-1:0] MIN_DIM = 7'd3;

   localparam logic BANK_FRONT = 1'b0;
   localparam logic BANK_BACK  = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FILL,
      ST_SYNC,
      ST_PASS,
      ST_GAP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic rd_bank;
      logic rd_pass;
      logic rd_last;
      logic ld_en;
      logic ld_border;
      logic fill_en;
   } dp_cmd_type;

   typedef struct packed {
      logic a_ready;
      logic pipe_empty;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/core/cags_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cags_ctrl: sequencer of the cave grid smoother
// Steps through load, fill, smoothing passes and emission, and drives the
// datapath with row addresses and commands.
// ----------------------------------------------------------------------------
module cags_ctrl
   import cags_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int RW = $clog2(MAX_ROWS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_last_row,
   output logic                     req_stall,
   input  wire logic [RW-1:0]       rows_m1,
   input  wire logic [PASS_W-1:0]   pass_count,
   input  wire dp_status_type       status,
   output dp_cmd_type               cmd,
   output logic [RW-1:0]            rd_row,
   output logic [RW-1:0]            wr_row
);

   state_type         state_ff, state_in;
   logic [RW-1:0]     load_idx_ff, load_idx_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [PASS_W-1:0] pass_ff, pass_in;

   logic [RW-1:0] load_idx;
   logic          load_at_last;
   logic          load_end;
   logic          row_at_last;

   assign load_idx     = (load_idx_ff > rows_m1) ? rows_m1 : load_idx_ff;
   assign load_at_last = (load_idx == rows_m1);
   assign load_end     = req_last_row || load_at_last;
   assign row_at_last  = (row_ff == rows_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_idx_ff <= '0;
         row_ff      <= '0;
         pass_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         load_idx_ff <= load_idx_in;
         row_ff      <= row_in;
         pass_ff     <= pass_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      load_idx_in = load_idx_ff;
      row_in      = row_ff;
      pass_in     = pass_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (load_end) begin
                  load_idx_in = '0;
                  if (load_at_last) begin
                     state_in = ST_SYNC;
                  end else begin
                     row_in   = load_idx + RW'(1);
                     state_in = ST_FILL;
                  end
               end else begin
                  load_idx_in = load_idx + RW'(1);
               end
            end
         end
         ST_FILL: begin
            if (row_at_last) begin
               state_in = ST_SYNC;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         ST_SYNC: begin
            if (status.pipe_empty) begin
               row_in  = '0;
               pass_in = '0;
               state_in = (pass_count == '0) ? ST_EMIT : ST_PASS;
            end
         end
         ST_PASS: begin
            if (row_at_last) begin
               row_in   = '0;
               state_in = ST_GAP;
            end else begin
               row_in = row_ff + RW'(1);
            end
         end
         ST_GAP: begin
            pass_in  = pass_ff + PASS_W'(1);
            state_in = (pass_ff == pass_count - PASS_W'(1)) ? ST_EMIT : ST_PASS;
         end
         ST_EMIT: begin
            if (status.a_ready) begin
               if (row_at_last) begin
                  row_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  row_in = row_ff + RW'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      rd_row    = row_ff;
      wr_row    = row_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall     = 1'b0;
            cmd.ld_en     = req_valid;
            cmd.ld_border = (load_idx == '0) || load_at_last;
            wr_row        = load_idx;
         end
         ST_FILL: begin
            cmd.fill_en = 1'b1;
         end
         ST_PASS: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_bank = pass_ff[0];
            cmd.rd_pass = 1'b1;
            cmd.rd_last = row_at_last;
         end
         ST_EMIT: begin
            cmd.rd_en   = status.a_ready;
            cmd.rd_bank = pass_count[0];
            cmd.rd_last = row_at_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/cags_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cags_dp: datapath of the cave grid smoother
// Two grid stores, a registered read stage, a three-row window with the 3x3
// wall count per column, and the result output register.
// ----------------------------------------------------------------------------
module cags_dp
   import cags_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   localparam int RW = $clog2(MAX_ROWS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   input  wire logic [RW-1:0]        rd_row,
   input  wire logic [RW-1:0]        wr_row,
   input  wire logic [COL_IDX_W-1:0] cols_m1,
   input  wire logic [THR_W-1:0]     wall_threshold,
   input  wire logic [CELL_W-1:0]    row_cells,
   output dp_status_type             status,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output logic [CELL_W-1:0]         rsp_out_cells,
   output logic                      rsp_out_last
);

   function automatic logic [CNT_W-1:0] ones9(input logic [8:0] v);
      logic [CNT_W-1:0] s;
      s = '0;
      for (int k = 0; k < 9; k++) begin
         s = s + CNT_W'(v[k]);
      end
      return s;
   endfunction

   logic [CELL_W-1:0] front_mem [MAX_ROWS];
   logic [CELL_W-1:0] back_mem  [MAX_ROWS];

   logic [CELL_W-1:0] a_data_ff;
   logic [RW-1:0]     a_row_ff;
   logic              a_v_ff, a_v_in;
   logic              a_pass_ff;
   logic              a_last_ff;
   logic              a_bank_ff;

   logic [CELL_W-1:0] win1_ff;
   logic [CELL_W-1:0] win2_ff;

   logic              tail_v_ff;
   logic [RW-1:0]     tail_row_ff;
   logic              tail_bank_ff;

   logic [CELL_W-1:0] b_data_ff;
   logic              b_last_ff;
   logic              b_v_ff, b_v_in;

   logic [CELL_W-1:0] col_mask, col_edge, col_inner;
   logic [CELL_W-1:0] load_row;
   logic [CELL_W-1:0] smooth_row;
   logic [CELL_W+1:0] prev_pad, cur_pad, next_pad;

   logic              b_ready, consume, a_move;
   logic              pw_en, pw_bank;
   logic [RW-1:0]     pw_row;
   logic [CELL_W-1:0] pw_data;

   logic              fw_en, bw_en;
   logic [RW-1:0]     fw_row, bw_row;
   logic [CELL_W-1:0] fw_data, bw_data;

   always_comb begin
      for (int j = 0; j < CELL_W; j++) begin
         col_mask[j]  = (COL_IDX_W'(j) <= cols_m1);
         col_edge[j]  = (j == 0) || (COL_IDX_W'(j) == cols_m1);
         col_inner[j] = (j != 0) && (COL_IDX_W'(j) < cols_m1);
      end
   end

   assign load_row = cmd.ld_border ? col_mask : ((row_cells & col_mask) | col_edge);

   // window: win1 = row above, win2 = center row, a_data = row below
   assign prev_pad = {1'b0, win1_ff, 1'b0};
   assign cur_pad  = {1'b0, win2_ff, 1'b0};
   assign next_pad = {1'b0, a_data_ff, 1'b0};

   always_comb begin
      for (int j = 0; j < CELL_W; j++) begin
         if (col_inner[j]) begin
            smooth_row[j] = (ones9({prev_pad[j +: 3], cur_pad[j +: 3], next_pad[j +: 3]})
                             >= wall_threshold);
         end else begin
            smooth_row[j] = col_edge[j] & win2_ff[j];
         end
      end
   end

   assign b_ready = !b_v_ff || !rsp_stall;
   assign consume = a_pass_ff || b_ready;
   assign a_move  = a_v_ff && !a_pass_ff && b_ready;

   assign status.a_ready    = !a_v_ff || consume;
   assign status.pipe_empty = !a_v_ff && !b_v_ff;

   // row r is written once row r+1 is in the read stage; top row is copied
   assign pw_en   = a_v_ff && a_pass_ff && (a_row_ff != '0);
   assign pw_row  = a_row_ff - RW'(1);
   assign pw_data = (a_row_ff == RW'(1)) ? win2_ff : smooth_row;
   assign pw_bank = ~a_bank_ff;

   always_comb begin
      fw_en   = 1'b0;
      fw_row  = wr_row;
      fw_data = col_mask;
      if (cmd.ld_en) begin
         fw_en   = 1'b1;
         fw_data = load_row;
      end else if (cmd.fill_en) begin
         fw_en   = 1'b1;
      end else if (pw_en && (pw_bank == BANK_FRONT)) begin
         fw_en   = 1'b1;
         fw_row  = pw_row;
         fw_data = pw_data;
      end else if (tail_v_ff && (tail_bank_ff == BANK_FRONT)) begin
         fw_en   = 1'b1;
         fw_row  = tail_row_ff;
         fw_data = win2_ff;
      end
   end

   always_comb begin
      bw_en   = 1'b0;
      bw_row  = pw_row;
      bw_data = pw_data;
      if (pw_en && (pw_bank == BANK_BACK)) begin
         bw_en = 1'b1;
      end else if (tail_v_ff && (tail_bank_ff == BANK_BACK)) begin
         bw_en   = 1'b1;
         bw_row  = tail_row_ff;
         bw_data = win2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fw_en) begin
         front_mem[fw_row] <= fw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (bw_en) begin
         back_mem[bw_row] <= bw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         a_data_ff <= (cmd.rd_bank == BANK_BACK) ? back_mem[rd_row] : front_mem[rd_row];
         a_row_ff  <= rd_row;
         a_pass_ff <= cmd.rd_pass;
         a_last_ff <= cmd.rd_last;
         a_bank_ff <= cmd.rd_bank;
      end
   end

   always_comb begin
      if (cmd.rd_en) begin
         a_v_in = 1'b1;
      end else begin
         a_v_in = a_v_ff && !consume;
      end
      b_v_in = b_ready ? (a_v_ff && !a_pass_ff) : b_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         tail_v_ff <= 1'b0;
      end else begin
         a_v_ff    <= a_v_in;
         b_v_ff    <= b_v_in;
         tail_v_ff <= a_v_ff && a_pass_ff && a_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      tail_row_ff  <= a_row_ff;
      tail_bank_ff <= ~a_bank_ff;
      if (a_v_ff && a_pass_ff) begin
         win1_ff <= win2_ff;
         win2_ff <= a_data_ff;
      end
      if (a_move) begin
         b_data_ff <= a_data_ff & col_mask;
         b_last_ff <= a_last_ff;
      end
   end

   assign rsp_valid     = b_v_ff;
   assign rsp_out_cells = b_data_ff;
   assign rsp_out_last  = b_last_ff;

endmodule
`default_nettype wire

// ===== rtl/core/cellular_automaton_grid_smoother_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cellular_automaton_grid_smoother_core: 3x3 cave smoothing engine
// Loads a wall/floor grid row by row, runs the configured smoothing passes
// between two row stores and emits the final grid row by row.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  one grid row per beat; req_last_row ends the load early (missing
//          rows become walls). The load also ends on the row that fills the
//          rows in use. Rows that do not end a load produce no output.
//   rsp_*  one beat per grid row after the load ends, rsp_out_last on the
//          final row.
//   csr_*  register writes, always ready; write only while the block idles.
// Sequence, with R rows in use and P passes:
//   load up to R rows (one row per cycle), fill the missing rows after an
//   early last row, sync until the datapath is empty, P smoothing passes (one
//   row read per cycle from the source store, a gap state between passes),
//   then R rows out at one per cycle unless rsp_stall holds them.
// Reset restores the register defaults and empties the output stages.
// A stalled result holds rsp_*; up to two rows wait inside, reading pauses.
// ----------------------------------------------------------------------------
module cellular_automaton_grid_smoother_core
   import cags_pkg::*;
#(
   parameter int MAX_ROWS = DEF_MAX_ROWS,
   parameter int MAX_COLS = DEF_MAX_COLS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CELL_W-1:0]     req_row_cells,
   input  wire logic                  req_last_row,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [CELL_W-1:0]          rsp_out_cells,
   output logic                       rsp_out_last,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RW = $clog2(MAX_ROWS);

   logic [DIM_W-1:0]  grid_rows_ff;
   logic [DIM_W-1:0]  grid_cols_ff;
   logic [PASS_W-1:0] pass_count_ff;
   logic [THR_W-1:0]  wall_threshold_ff;

   logic [RW-1:0]        rows_m1;
   logic [COL_IDX_W-1:0] cols_m1;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [RW-1:0] rd_row;
   logic [RW-1:0] wr_row;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff      <= RST_GRID_ROWS;
         grid_cols_ff      <= RST_GRID_COLS;
         pass_count_ff     <= RST_PASS_COUNT;
         wall_threshold_ff <= RST_WALL_THRESHOLD;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_ROWS:      grid_rows_ff      <= csr_wdata[DIM_W-1:0];
            CSR_GRID_COLS:      grid_cols_ff      <= csr_wdata[DIM_W-1:0];
            CSR_PASS_COUNT:     pass_count_ff     <= csr_wdata[PASS_W-1:0];
            CSR_WALL_THRESHOLD: wall_threshold_ff <= csr_wdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (int'(grid_rows_ff) > MAX_ROWS) begin
         rows_m1 = RW'(MAX_ROWS - 1);
      end else if (grid_rows_ff < MIN_DIM) begin
         rows_m1 = RW'(MIN_DIM - 7'd1);
      end else begin
         rows_m1 = RW'(grid_rows_ff - 7'd1);
      end
   end

   always_comb begin
      if (int'(grid_cols_ff) > MAX_COLS) begin
         cols_m1 = COL_IDX_W'(MAX_COLS - 1);
      end else if (grid_cols_ff < MIN_DIM) begin
         cols_m1 = COL_IDX_W'(MIN_DIM - 7'd1);
      end else begin
         cols_m1 = COL_IDX_W'(grid_cols_ff - 7'd1);
      end
   end

   cags_ctrl #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_last_row),
      .req_stall    (req_stall),
      .rows_m1      (rows_m1),
      .pass_count   (pass_count_ff),
      .status       (status),
      .cmd          (cmd),
      .rd_row       (rd_row),
      .wr_row       (wr_row)
   );

   cags_dp #(
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .rd_row         (rd_row),
      .wr_row         (wr_row),
      .cols_m1        (cols_m1),
      .wall_threshold (wall_threshold_ff),
      .row_cells      (req_row_cells),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_out_cells  (rsp_out_cells),
      .rsp_out_last   (rsp_out_last)
   );

endmodule
`default_nettype wire

// ===== rtl/core/cags_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cags_checker: port-level checks of the cave grid smoother
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module cags_checker
   import cags_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [CELL_W-1:0] rsp_out_cells,
   input wire logic              rsp_out_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_cells) && $stable(rsp_out_last))
      else $error("stalled result beat changed");

   a_left_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_cells[0])
      else $error("left border column is not a wall");

   a_grid_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_out_last |=> !rsp_valid)
      else $error("result beat right after the final row");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cellular_automaton_grid_smoother_core cags_checker u_cags_checker (.*);
`default_nettype wire
